// ===== rtl/fqrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fqrc_pkg
// Shared types, character codes and helpers for the FASTQ record counter.
// ----------------------------------------------------------------------------
package fqrc_pkg;

    localparam int COUNT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic [31:0] read_count;
        logic        new_read;
        logic        record_done;
        logic        bad_header;
        logic        warn_at_in_quality;
        logic        warn_extra_quality;
        logic        stream_done;
    } result_t;

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/fastq_record_counter.sv =====
// ----------------------------------------------------------------------------
// fastq_record_counter
// Byte-stream FASTQ record counter with multi-line sequence/quality support.
// ----------------------------------------------------------------------------
// Usage:
//   item / item_valid / item_ready carry one text byte per request, with
//   stream_end set on the final byte. result / result_valid / result_ready
//   return exactly one result per byte, in order.
//   An accepted byte waits in the input register and is parsed into the
//   result register once that register is empty or its result is taken.
//   Throughput: one byte per cycle while the receiver keeps taking results;
//   parse state is updated by a single pass
//   of compare and saturating-add logic between input and result registers.
//   A stalled receiver holds the result register; the input register keeps
//   taking one more request, after which item_ready drops until the result is taken.
//   Reset clears both registers' valid flags and returns the parser to the
//   header phase with all counters and the error flag at zero.
// ----------------------------------------------------------------------------
module fastq_record_counter
    import fqrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    stage_vld_reg;
    item_t   stage_reg;
    logic    res_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    assign advance      = stage_vld_reg && (!res_vld_reg || result_ready);
    assign item_ready   = !stage_vld_reg || advance;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    fqrc_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (advance),
        .item   (stage_reg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                stage_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/fqrc_parse_core.sv =====
// ----------------------------------------------------------------------------
// fqrc_parse_core
// Line tracking, phase state and saturating counters; one byte per enable.
// ----------------------------------------------------------------------------
module fqrc_parse_core
    import fqrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    enable,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SEQ    = 2'd1,
        PH_PLUS   = 2'd2,
        PH_QUAL   = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       start_reg, start_next;
    logic       plus_reg, plus_next;
    logic       nonempty_reg, nonempty_next;
    logic       ended_reg, ended_next;
    logic [7:0] first_reg, first_next;
    count_t     len_reg, len_next;
    count_t     base_reg, base_next;
    count_t     qual_reg, qual_next;
    count_t     rec_reg, rec_next;
    logic       err_reg, err_next;

    logic       term;
    logic       line_end;
    logic       new_read;
    logic       done;
    logic       warn_at;
    logic       warn_extra;
    count_t     qsum;

    assign term     = (item.text_byte == CH_NUL) || (item.text_byte == CH_LF) ||
                      (item.text_byte == CH_CR);
    assign line_end = (item.text_byte == CH_LF) || item.stream_end;

    always_comb
    begin
        phase_next    = phase_reg;
        start_next    = start_reg;
        plus_next     = plus_reg;
        nonempty_next = nonempty_reg;
        ended_next    = ended_reg;
        first_next    = first_reg;
        len_next      = len_reg;
        base_next     = base_reg;
        qual_next     = qual_reg;
        rec_next      = rec_reg;
        err_next      = err_reg;
        new_read      = 1'b0;
        done          = 1'b0;
        warn_at       = 1'b0;
        warn_extra    = 1'b0;
        qsum          = '0;

        if (!err_reg)
        begin
            if (start_reg)
            begin
                first_next    = item.text_byte;
                plus_next     = (item.text_byte == CH_PLUS);
                nonempty_next = !term;
                ended_next    = 1'b0;
                len_next      = '0;
                start_next    = 1'b0;
            end
            else if (first_reg == CH_CR && item.text_byte != CH_LF)
            begin
                nonempty_next = 1'b1;
            end

            if (!ended_next)
            begin
                if (term)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    len_next = sat_add(len_next, count_t'(1));
                end
            end

            if (line_end)
            begin
                start_next = 1'b1;
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (nonempty_next)
                        begin
                            if (first_next != CH_AT)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                rec_next   = sat_add(rec_reg, count_t'(1));
                                base_next  = '0;
                                phase_next = PH_SEQ;
                                new_read   = 1'b1;
                            end
                        end
                    end
                    PH_SEQ:
                    begin
                        if (plus_next)
                        begin
                            qual_next  = '0;
                            phase_next = PH_PLUS;
                        end
                        else
                        begin
                            base_next = sat_add(base_reg, len_next);
                        end
                    end
                    PH_PLUS, PH_QUAL:
                    begin
                        warn_at    = (phase_reg == PH_QUAL) && (first_next == CH_AT);
                        qsum       = sat_add(qual_reg, len_next);
                        qual_next  = qsum;
                        phase_next = PH_QUAL;
                        if (qsum >= base_reg)
                        begin
                            phase_next = PH_HEADER;
                            done       = 1'b1;
                            warn_extra = (qsum > base_reg);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            start_reg    <= 1'b1;
            plus_reg     <= 1'b0;
            nonempty_reg <= 1'b0;
            ended_reg    <= 1'b0;
            first_reg    <= CH_NUL;
            len_reg      <= '0;
            base_reg     <= '0;
            qual_reg     <= '0;
            rec_reg      <= '0;
            err_reg      <= 1'b0;
        end
        else if (enable)
        begin
            phase_reg    <= phase_next;
            start_reg    <= start_next;
            plus_reg     <= plus_next;
            nonempty_reg <= nonempty_next;
            ended_reg    <= ended_next;
            first_reg    <= first_next;
            len_reg      <= len_next;
            base_reg     <= base_next;
            qual_reg     <= qual_next;
            rec_reg      <= rec_next;
            err_reg      <= err_next;
        end
    end

    always_comb
    begin
        result.read_count         = 32'(rec_next);
        result.new_read           = new_read;
        result.record_done        = done;
        result.bad_header         = err_next;
        result.warn_at_in_quality = warn_at;
        result.warn_extra_quality = warn_extra;
        result.stream_done        = item.stream_end;
    end

    // error freezes the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg && $stable(rec_reg) && $stable(phase_reg))
    else $error("parser state moved after error");

    assert property (@(posedge clk) disable iff (!rst_n)
        enable && done |=> phase_reg == PH_HEADER)
    else $error("record completion did not return to header phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        warn_extra |-> done)
    else $error("extra quality warning without record completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        enable && new_read |=> rec_reg != '0 && phase_reg == PH_SEQ)
    else $error("new read not reflected in count or phase");

endmodule

// ===== bench/fastq_record_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fastq_record_counter_test
// Drives FASTQ text into the record counter one byte per request. A short
// table of hand-picked bytes comes first, then randomly built records with
// noisy content, then a bad header line and random bytes. Results are checked
// per field against typed rows' values, else the bench's behavioural parser.
// ----------------------------------------------------------------------------
module fastq_record_counter_test;
    import fqrc_pkg::*;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 600;
    localparam int LIMIT      = 200000;

    typedef enum logic [1:0] {PH_HEADER, PH_SEQUENCE, PH_PLUS, PH_QUALITY} phase_t;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       typed;
        result_t    want;
    } row_t;

    localparam result_t QUIET      = '0;
    localparam result_t FIRST_READ = {32'd1, 6'b100000};
    localparam result_t LAST_BYTE  = {32'd2, 6'b010011};

    localparam row_t DIRECTED [N_DIRECTED] = '{
        // empty lines in the header phase: LF, CR LF, NUL-led
        {CH_LF,   1'b0, 1'b1, QUIET},
        {CH_CR,   1'b0, 1'b1, QUIET},
        {CH_LF,   1'b0, 1'b1, QUIET},
        {CH_NUL,  1'b0, 1'b1, QUIET},
        {8'hFF,   1'b0, 1'b1, QUIET},
        {CH_LF,   1'b0, 1'b1, QUIET},
        {CH_AT,   1'b0, 1'b1, QUIET},
        {CH_LF,   1'b0, 1'b1, FIRST_READ},
        // two sequence lines, CR cuts the first
        {"A",     1'b0, 1'b0, QUIET},
        {"C",     1'b0, 1'b0, QUIET},
        {CH_CR,   1'b0, 1'b0, QUIET},
        {CH_LF,   1'b0, 1'b0, QUIET},
        {"G",     1'b0, 1'b0, QUIET},
        {CH_LF,   1'b0, 1'b0, QUIET},
        {CH_PLUS, 1'b0, 1'b0, QUIET},
        {CH_LF,   1'b0, 1'b0, QUIET},
        {"I",     1'b0, 1'b0, QUIET},
        {CH_LF,   1'b0, 1'b0, QUIET},
        // continuing quality line led by '@'
        {CH_AT,   1'b0, 1'b0, QUIET},
        {"I",     1'b0, 1'b0, QUIET},
        {CH_LF,   1'b0, 1'b0, QUIET},
        // empty read, lines closed by stream end, surplus quality
        {CH_AT,   1'b0, 1'b0, QUIET},
        {CH_LF,   1'b0, 1'b0, QUIET},
        {CH_PLUS, 1'b1, 1'b0, QUIET},
        {"I",     1'b1, 1'b1, LAST_BYTE}
    };

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    fastq_record_counter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    row_t    stim [$];
    result_t expected_q [$];
    int      tail_start;
    int      n_taken  = 0;
    int      n_errors = 0;
    int      n_cycles = 0;
    bit      steady   = 0;
    result_t guess;

    // parser state
    phase_t     ph         = PH_HEADER;
    logic       line_start = 1'b1;
    logic       plus_line  = 1'b0;
    logic       has_text   = 1'b0;
    logic       cut        = 1'b0;
    logic       halted     = 1'b0;
    logic [7:0] lead       = '0;
    count_t     len        = '0;
    count_t     bases      = '0;
    count_t     quals      = '0;
    count_t     n_reads    = '0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic count_t add_sat(input count_t a, input count_t b);
        return (a > ~b) ? '1 : a + b;
    endfunction

    function automatic result_t parse_byte(input item_t req);
        result_t    r;
        logic [7:0] c;
        logic       brk;
        r   = '0;
        c   = req.text_byte;
        brk = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
        if (!halted)
        begin
            if (line_start)
            begin
                lead       = c;
                plus_line  = (c == CH_PLUS);
                has_text   = !brk;
                cut        = 1'b0;
                len        = '0;
                line_start = 1'b0;
            end
            else if (lead == CH_CR && c != CH_LF)
                has_text = 1'b1;
            if (!cut)
            begin
                if (brk)
                    cut = 1'b1;
                else
                    len = add_sat(len, count_t'(1));
            end
            if (c == CH_LF || req.stream_end)
            begin
                line_start = 1'b1;
                case (ph)
                    PH_HEADER:
                        if (has_text)
                        begin
                            if (lead != CH_AT)
                                halted = 1'b1;
                            else
                            begin
                                n_reads    = add_sat(n_reads, count_t'(1));
                                bases      = '0;
                                ph         = PH_SEQUENCE;
                                r.new_read = 1'b1;
                            end
                        end
                    PH_SEQUENCE:
                        if (plus_line)
                        begin
                            quals = '0;
                            ph    = PH_PLUS;
                        end
                        else
                            bases = add_sat(bases, len);
                    default:
                    begin
                        r.warn_at_in_quality = (ph == PH_QUALITY) && (lead == CH_AT);
                        ph    = PH_QUALITY;
                        quals = add_sat(quals, len);
                        if (quals >= bases)
                        begin
                            ph                   = PH_HEADER;
                            r.record_done        = 1'b1;
                            r.warn_extra_quality = (quals > bases);
                        end
                    end
                endcase
            end
        end
        r.read_count  = n_reads[31:0];
        r.bad_header  = halted;
        r.stream_done = req.stream_end;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte(input bit clean);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF || (clean && (c == CH_NUL || c == CH_CR)));
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] c, input logic last);
        stim.push_back(row_t'({c, last, 1'b0, QUIET}));
    endtask

    // One line: optional lead byte, body, optional CR, then LF or a stream end.
    // n_len returns the content length as the parser will count it.
    task automatic put_line(input int first, input int body, input bit clean,
                            output int n_len);
        logic [7:0] c;
        bit         stop;
        int         n_bytes;
        n_len   = 0;
        stop    = 0;
        n_bytes = 0;
        for (int k = -1; k <= body; k++)
        begin
            if (k == -1 && first < 0)
                continue;
            if (k == body)
            begin
                if ($urandom_range(0, 3) != 0)
                    continue;
                c = CH_CR;
            end
            else
                c = (k == -1) ? first[7:0] : rand_byte(clean);
            if (c == CH_NUL || c == CH_CR)
                stop = 1;
            else if (!stop)
                n_len++;
            push_byte(c, 1'b0);
            n_bytes++;
        end
        if ($urandom_range(0, 24) == 0 && n_bytes > 0 && $urandom_range(0, 1) == 1)
            stim[stim.size()-1].last = 1'b1;
        else
            push_byte(CH_LF, $urandom_range(0, 24) == 0);
    endtask

    task automatic put_record();
        int         n_len;
        int         bases_left;
        int         k;
        bit         closed;
        logic [7:0] c;
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(0, 1))
                put_line(-1, 0, 0, n_len);
            else
                put_line(CH_NUL, $urandom_range(0, 4), 0, n_len);
        end
        put_line(CH_AT, $urandom_range(0, 6), 0, n_len);
        bases_left = 0;
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 5) == 0)
                put_line(-1, 0, 0, n_len);
            else
            begin
                do
                    c = rand_byte(0);
                while (c == CH_PLUS);
                put_line(c, $urandom_range(0, 10), 0, n_len);
            end
            bases_left += n_len;
        end
        put_line(CH_PLUS, $urandom_range(0, 4), 0, n_len);
        closed = 0;
        while (!closed)
        begin
            if (bases_left == 0)
                k = $urandom_range(0, 2);
            else if ($urandom_range(0, 9) == 0)
                k = 0;
            else
            begin
                k = $urandom_range(1, bases_left);
                if ($urandom_range(0, 7) == 0)
                    k += $urandom_range(1, 3);
            end
            closed     = (k >= bases_left);
            bases_left = closed ? 0 : bases_left - k;
            if (k == 0)
                put_line(-1, 0, 1, n_len);
            else
                put_line(($urandom_range(0, 3) == 0) ? CH_AT : rand_byte(1), k - 1, 1, n_len);
        end
    endtask

    task automatic build_stimulus();
        int         n_len;
        logic [7:0] c;
        foreach (DIRECTED[i])
            stim.push_back(DIRECTED[i]);
        while (stim.size() < N_DIRECTED + N_RANDOM)
            put_record();
        // bad header freezes the parser, so it goes last
        tail_start = stim.size();
        if ($urandom_range(0, 1))
            put_line(CH_CR, $urandom_range(1, 4), 0, n_len);
        else
        begin
            do
                c = rand_byte(0);
            while (c == CH_AT || c == CH_NUL || c == CH_CR);
            put_line(c, $urandom_range(0, 4), 0, n_len);
        end
        repeat (20)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_result(input result_t want, input result_t got);
        check_field("read_count", want.read_count, got.read_count);
        check_field("new_read", want.new_read, got.new_read);
        check_field("record_done", want.record_done, got.record_done);
        check_field("bad_header", want.bad_header, got.bad_header);
        check_field("warn_at_in_quality", want.warn_at_in_quality, got.warn_at_in_quality);
        check_field("warn_extra_quality", want.warn_extra_quality, got.warn_extra_quality);
        check_field("stream_done", want.stream_done, got.stream_done);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                guess = parse_byte(item);
                expected_q.push_back(stim[n_taken].typed ? stim[n_taken].want : guess);
                n_taken++;
            end
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %0h", $time, result);
                    n_errors++;
                end
                else
                    check_result(expected_q.pop_front(), result);
            end
        end
    end

    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ready <= steady || ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == LIMIT)
        begin
            $display("** fastq_record_counter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < stim.size(); i++)
        begin
            steady = (i >= N_DIRECTED + 250) && (i < N_DIRECTED + 400);
            // hold off until the block has drained
            if (i == N_DIRECTED || i == tail_start)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (expected_q.size() != 0) @(posedge clk);
            end
            while (!steady && $urandom_range(0, 99) < 28)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item       <= {stim[i].text, stim[i].last};
            item_valid <= 1'b1;
            @(posedge clk);
            while (!item_ready) @(posedge clk);
        end
        steady = 0;
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("** fastq_record_counter: PASSED **");
        else
            $display("** fastq_record_counter: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fqrc_pkg.sv
rtl/fqrc_parse_core.sv
rtl/fastq_record_counter.sv
bench/fastq_record_counter_test.sv
